### sv/owt_pkg.sv
// ----------------------------------------------------------------------------
// owt_pkg
// Shared types and codes for the one-wire bit timing master: phase codes,
// opcodes, error codes, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package owt_pkg;

  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int PHASE_W     = 4;
  localparam int ERR_W       = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TIMEOUT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WINDOW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ONE_LOW      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ZERO_LOW     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE_WINDOW = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SLOT_LENGTH   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVER_TIMEOUT    = 3'd7;

  // Register reset values
  localparam logic [9:0] RST_RESET_LOW_TICKS    = 10'd480;
  localparam logic [7:0] RST_RELEASE_TIMEOUT    = 8'd15;
  localparam logic [9:0] RST_PRESENCE_WINDOW    = 10'd240;
  localparam logic [7:0] RST_WRITE_ONE_LOW      = 8'd2;
  localparam logic [7:0] RST_WRITE_ZERO_LOW     = 8'd62;
  localparam logic [7:0] RST_READ_SAMPLE_WINDOW = 8'd15;
  localparam logic [7:0] RST_READ_SLOT_LENGTH   = 8'd60;
  localparam logic [7:0] RST_RECOVER_TIMEOUT    = 8'd120;

  // Opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NOT_RELEASED = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_PRESENCE  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_HELD_LOW     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NOT_LOW      = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NOT_HIGH     = 3'd5;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE          = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RST_LOW       = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RST_WAIT_HIGH = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RST_WAIT_PRES = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RST_WAIT_REL  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_RST_RECOVER   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_CONF_LOW   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WR_HOLD       = 4'd7;
  localparam logic [PHASE_W-1:0] PH_WR_WAIT_HIGH  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_WR_FINISH     = 4'd9;
  localparam logic [PHASE_W-1:0] PH_RD_CONF_LOW   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_RD_HOLD       = 4'd11;
  localparam logic [PHASE_W-1:0] PH_RD_SAMPLE     = 4'd12;
  localparam logic [PHASE_W-1:0] PH_RD_FINISH     = 4'd13;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] release_timeout;
    logic [9:0] presence_window;
    logic [7:0] write_one_low;
    logic [7:0] write_zero_low;
    logic [7:0] read_sample_window;
    logic [7:0] read_slot_length;
    logic [7:0] recover_timeout;
  } cfg_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy;
    logic             done;
    logic             presence;
    logic             read_value;
    logic [ERR_W-1:0] error_code;
  } res_t;

endpackage

### sv/owt_cfg.sv
// ----------------------------------------------------------------------------
// owt_cfg
// Timing register bank: eight write-only registers, loaded by index.
// ----------------------------------------------------------------------------
module owt_cfg
  import owt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks    <= RST_RESET_LOW_TICKS;
      cfg.release_timeout    <= RST_RELEASE_TIMEOUT;
      cfg.presence_window    <= RST_PRESENCE_WINDOW;
      cfg.write_one_low      <= RST_WRITE_ONE_LOW;
      cfg.write_zero_low     <= RST_WRITE_ZERO_LOW;
      cfg.read_sample_window <= RST_READ_SAMPLE_WINDOW;
      cfg.read_slot_length   <= RST_READ_SLOT_LENGTH;
      cfg.recover_timeout    <= RST_RECOVER_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW_TICKS:    cfg.reset_low_ticks    <= cfg_data;
        REG_RELEASE_TIMEOUT:    cfg.release_timeout    <= cfg_data[7:0];
        REG_PRESENCE_WINDOW:    cfg.presence_window    <= cfg_data;
        REG_WRITE_ONE_LOW:      cfg.write_one_low      <= cfg_data[7:0];
        REG_WRITE_ZERO_LOW:     cfg.write_zero_low     <= cfg_data[7:0];
        REG_READ_SAMPLE_WINDOW: cfg.read_sample_window <= cfg_data[7:0];
        REG_READ_SLOT_LENGTH:   cfg.read_slot_length   <= cfg_data[7:0];
        REG_RECOVER_TIMEOUT:    cfg.recover_timeout    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/owt_fsm.sv
// ----------------------------------------------------------------------------
// owt_fsm
// Bit timing sequencer: phase register, two saturating tick counters and
// status flags, advanced once per accepted tick request.
// ----------------------------------------------------------------------------
module owt_fsm
  import owt_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = 10
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_t       cfg,
  input  logic [1:0] opcode,
  input  logic       write_value,
  input  logic       bus_level,
  output res_t       res
);

  localparam int CW    = TICK_COUNTER_BITS;
  localparam int CMP_W = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [CW-1:0]      anchor, anchor_next;
  logic [CW-1:0]      since_low, since_low_next;
  logic               pending_bit, pending_bit_next;
  logic               presence_flag, presence_flag_next;
  logic               sampled_bit, sampled_bit_next;
  logic [ERR_W-1:0]   last_error, last_error_next;
  logic               done;
  logic [PHASE_W-1:0] cur;
  logic [7:0]         hold;

  // A saturated counter is past every limit.
  function automatic logic past(input logic [CW-1:0] cnt, input logic [9:0] lim);
    return (CMP_W'(cnt) > CMP_W'(lim)) || (cnt == CNT_MAX);
  endfunction

  function automatic logic reached(input logic [CW-1:0] cnt, input logic [9:0] lim);
    return (CMP_W'(cnt) >= CMP_W'(lim)) || (cnt == CNT_MAX);
  endfunction

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] cnt);
    return (cnt == CNT_MAX) ? cnt : cnt + CW'(1);
  endfunction

  always_comb begin
    cur                = (phase > PH_RD_FINISH) ? PH_IDLE : phase;
    phase_next         = cur;
    anchor_next        = anchor;
    since_low_next     = since_low;
    pending_bit_next   = pending_bit;
    presence_flag_next = presence_flag;
    sampled_bit_next   = sampled_bit;
    last_error_next    = last_error;
    done               = 1'b0;
    hold               = pending_bit ? cfg.write_one_low : cfg.write_zero_low;

    if (cur == PH_IDLE) begin
      if (opcode != OP_TICK) begin
        anchor_next     = '0;
        since_low_next  = '0;
        last_error_next = ERR_NONE;
        case (opcode)
          OP_RESET: begin
            presence_flag_next = 1'b0;
            phase_next         = PH_RST_LOW;
          end
          OP_WRITE: begin
            pending_bit_next = write_value;
            phase_next       = PH_WR_CONF_LOW;
          end
          default: phase_next = PH_RD_CONF_LOW;
        endcase
      end
    end else begin
      anchor_next    = bump(anchor);
      since_low_next = bump(since_low);
      case (cur)
        PH_RST_LOW: begin
          if (reached(anchor_next, cfg.reset_low_ticks)) begin
            anchor_next = '0;
            phase_next  = PH_RST_WAIT_HIGH;
          end
        end
        PH_RST_WAIT_HIGH: begin
          if (past(anchor_next, 10'(cfg.release_timeout))) begin
            if (last_error_next == ERR_NONE) last_error_next = ERR_NOT_RELEASED;
            phase_next = PH_RST_RECOVER;
          end else if (bus_level) begin
            since_low_next = '0;
            phase_next     = PH_RST_WAIT_PRES;
          end
        end
        PH_RST_WAIT_PRES: begin
          if (past(since_low_next, cfg.presence_window)) begin
            if (last_error_next == ERR_NONE) last_error_next = ERR_NO_PRESENCE;
            phase_next = PH_RST_RECOVER;
          end else if (!bus_level) begin
            presence_flag_next = 1'b1;
            phase_next         = PH_RST_WAIT_REL;
          end
        end
        PH_RST_WAIT_REL: begin
          if (past(anchor_next, cfg.reset_low_ticks)) begin
            if (last_error_next == ERR_NONE) last_error_next = ERR_HELD_LOW;
            phase_next = PH_RST_RECOVER;
          end else if (bus_level) begin
            phase_next = PH_RST_RECOVER;
          end
        end
        PH_WR_CONF_LOW, PH_RD_CONF_LOW: begin
          if (past(anchor_next, 10'(cfg.release_timeout)) || !bus_level) begin
            if (bus_level && last_error_next == ERR_NONE) last_error_next = ERR_NOT_LOW;
            since_low_next = '0;
            phase_next     = (cur == PH_WR_CONF_LOW) ? PH_WR_HOLD : PH_RD_HOLD;
          end
        end
        PH_WR_HOLD: begin
          if (past(since_low_next, 10'(hold))) phase_next = PH_WR_WAIT_HIGH;
        end
        PH_WR_WAIT_HIGH: begin
          if (past(since_low_next, 10'(cfg.recover_timeout))) begin
            if (last_error_next == ERR_NONE) last_error_next = ERR_NOT_HIGH;
            phase_next = PH_WR_FINISH;
          end else if (bus_level) begin
            phase_next = PH_WR_FINISH;
          end
        end
        PH_RD_HOLD: begin
          if (past(since_low_next, 10'(cfg.write_one_low))) phase_next = PH_RD_SAMPLE;
        end
        PH_RD_SAMPLE: begin
          if (past(since_low_next, 10'(cfg.read_sample_window))) begin
            sampled_bit_next = 1'b0;
            phase_next       = PH_RD_FINISH;
          end else if (bus_level) begin
            sampled_bit_next = 1'b1;
            phase_next       = PH_RD_FINISH;
          end
        end
        default: ;
      endcase

      // End of operation: recovery or slot length run out
      if ((phase_next == PH_RST_RECOVER && past(anchor_next, cfg.reset_low_ticks)) ||
          (phase_next == PH_WR_FINISH &&
           past(since_low_next, 10'(cfg.write_zero_low))) ||
          (phase_next == PH_RD_FINISH &&
           past(since_low_next, 10'(cfg.read_slot_length)))) begin
        phase_next = PH_IDLE;
        done       = 1'b1;
      end
    end

    res.drive_low  = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_CONF_LOW) ||
                     (phase_next == PH_WR_HOLD) || (phase_next == PH_RD_CONF_LOW) ||
                     (phase_next == PH_RD_HOLD);
    res.busy       = (phase_next != PH_IDLE);
    res.done       = done;
    res.presence   = presence_flag_next;
    res.read_value = sampled_bit_next;
    res.error_code = last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      anchor        <= '0;
      since_low     <= '0;
      pending_bit   <= 1'b0;
      presence_flag <= 1'b0;
      sampled_bit   <= 1'b0;
      last_error    <= ERR_NONE;
    end else if (step) begin
      phase         <= phase_next;
      anchor        <= anchor_next;
      since_low     <= since_low_next;
      pending_bit   <= pending_bit_next;
      presence_flag <= presence_flag_next;
      sampled_bit   <= sampled_bit_next;
      last_error    <= last_error_next;
    end
  end

endmodule

### sv/one_wire_bit_timing_master.sv
// ----------------------------------------------------------------------------
// one_wire_bit_timing_master
// Tick-driven one-wire bus master for bus reset, single bit write and
// single bit read slots, with timeouts reported as error codes.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per microsecond tick on the input channel (in_valid /
//   in_ready). It carries the sampled line level and, while idle, an opcode
//   (tick, reset, write bit, read bit). Every request yields exactly one
//   result on the output channel (out_valid / out_ready): the line drive,
//   busy, done, presence, read bit and error code after that tick.
//   The result is registered: a request taken at one edge shows its result
//   after that edge. Throughput is one request per cycle while results are
//   taken; each takes a single pass of counter compare and phase select.
//   The output register frees up in the same cycle it is taken, so the
//   input stays ready while the receiver keeps pace; when the receiver
//   stalls, hold the result and drop in_ready until it is taken.
//   Timing registers are written through cfg_we / cfg_index / cfg_data at
//   any edge, with no read-back; write them while no operation runs.
//   Synchronous reset returns the sequencer to idle, clears flags and
//   errors, empties the output register and loads register defaults.
// ----------------------------------------------------------------------------
module one_wire_bit_timing_master
  import owt_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = 10
)
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // tick requests
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic                   write_value,
  input  logic                   bus_level,
  // results
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   drive_low,
  output logic                   busy_res,
  output logic                   done_res,
  output logic                   presence,
  output logic                   read_value,
  output logic [ERR_W-1:0]       error_code
);

  cfg_t cfg;
  res_t res_next;
  res_t res;
  logic accept;

  // Take a request whenever the result slot is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  owt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owt_fsm #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .cfg         (cfg),
    .opcode      (opcode),
    .write_value (write_value),
    .bus_level   (bus_level),
    .res         (res_next)
  );

  // Result register: load on accept, clear valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign drive_low  = res.drive_low;
  assign busy_res   = res.busy;
  assign done_res   = res.done;
  assign presence   = res.presence;
  assign read_value = res.read_value;
  assign error_code = res.error_code;

endmodule

### sv/owt_chk.sv
// ----------------------------------------------------------------------------
// owt_chk
// Port-level checks for the one-wire bit timing master, bound to the top.
// ----------------------------------------------------------------------------
module owt_chk
  import owt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             drive_low,
  input logic             busy_res,
  input logic             done_res,
  input logic [ERR_W-1:0] error_code
);

  // Every accepted request leaves a result waiting.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

  // An empty result slot never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(drive_low) &&
    $stable(busy_res) && $stable(done_res) && $stable(error_code))
    else $error("stalled result changed");

  // Finishing returns to idle and releases the line.
  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !drive_low))
    else $error("done reported while busy or driving");

endmodule

bind one_wire_bit_timing_master owt_chk u_owt_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .drive_low  (drive_low),
  .busy_res   (busy_res),
  .done_res   (done_res),
  .error_code (error_code)
);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// one_wire_bit_timing_master testbench
// Sends microsecond tick requests whose line level reacts to the master's
// drive like a device would: clean slaves, stuck lines, noise and slaves
// that hold the line too long. Timing registers are swept from all-zero
// through small random values to the defaults and to long limits that only
// end by counter saturation. Every result is checked field by field against
// a cycle-exact model of the sequencer.
// ----------------------------------------------------------------------------
module testbench;
  import owt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Counter saturation value of the sequencer (TICK_COUNTER_BITS = 10)
  localparam logic [9:0] TICK_CNT_MAX = 10'h3FF;

  // Device behaviors used to shape the line level
  localparam int DEV_NICE       = 0;
  localparam int DEV_STUCK_HIGH = 1;
  localparam int DEV_STUCK_LOW  = 2;
  localparam int DEV_NOISE      = 3;
  localparam int DEV_HOLD_LOW   = 4;

  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [9:0]         anchor;
    logic [9:0]         since_low;
    logic               pend_bit;
    logic               presence;
    logic               sampled;
    logic [ERR_W-1:0]   err;
  } line_state_t;

  typedef struct packed {
    line_state_t st;
    res_t        res;
  } step_t;

  typedef struct packed {
    logic [1:0] op;
    logic       wv;
    logic       lvl;
  } tick_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             opcode = OP_TICK;
  logic                   write_value = 1'b0;
  logic                   bus_level = 1'b1;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   drive_low;
  logic                   busy_res;
  logic                   done_res;
  logic                   presence;
  logic                   read_value;
  logic [ERR_W-1:0]       error_code;

  // Requests waiting to be sent, and expected results of sent requests
  tick_req_t   pending_ticks[$];
  res_t        expected_status[$];

  // Planner copy: used to make the line react to the master's drive
  line_state_t plan_state;
  cfg_t        plan_cfg;
  int          plan_tip;
  int          planned;
  // Checker copy: advanced on every accepted request
  line_state_t shadow_state;
  cfg_t        shadow_cfg;
  int          accepted = 0;

  // Per-operation device behavior
  int          op_style;
  int          op_lag;
  int          op_pres_at;
  int          op_rel_at;
  int          op_zero_len;
  logic        op_bit;

  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          req_taken = 1'b0;
  int          fail_count = 0;
  tick_req_t   next_req;
  step_t       shadow_step;
  res_t        want;

  one_wire_bit_timing_master i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .write_value (write_value),
    .bus_level   (bus_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_low   (drive_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .presence    (presence),
    .read_value  (read_value),
    .error_code  (error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------

  // A saturated counter counts as past any limit
  function automatic logic beyond(input logic [9:0] cnt, input logic [9:0] lim);
    return (cnt > lim) || (cnt == TICK_CNT_MAX);
  endfunction

  function automatic logic reached(input logic [9:0] cnt, input logic [9:0] lim);
    return (cnt >= lim) || (cnt == TICK_CNT_MAX);
  endfunction

  function automatic logic [9:0] bump(input logic [9:0] cnt);
    return (cnt == TICK_CNT_MAX) ? cnt : cnt + 10'd1;
  endfunction

  // Keep only the first error of an operation
  function automatic logic [ERR_W-1:0] first_error(input logic [ERR_W-1:0] cur,
                                                   input logic [ERR_W-1:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  // Advance one tick: returns the new state and the status after the tick
  function automatic step_t advance_line(input line_state_t s, input cfg_t c,
                                         input logic [1:0] op, input logic wv,
                                         input logic lvl);
    step_t      r;
    logic [7:0] hold;
    logic       fin;
    r = '0;
    r.st = s;
    fin = 1'b0;
    if (r.st.phase > PH_RD_FINISH) r.st.phase = PH_IDLE;
    if (r.st.phase == PH_IDLE) begin
      // opcodes count only while idle; write_value is latched here
      if (op != OP_TICK) begin
        r.st.anchor = '0;
        r.st.since_low = '0;
        r.st.err = ERR_NONE;
        case (op)
          OP_RESET: begin
            r.st.presence = 1'b0;
            r.st.phase = PH_RST_LOW;
          end
          OP_WRITE: begin
            r.st.pend_bit = wv;
            r.st.phase = PH_WR_CONF_LOW;
          end
          default: r.st.phase = PH_RD_CONF_LOW;
        endcase
      end
    end else begin
      r.st.anchor = bump(r.st.anchor);
      r.st.since_low = bump(r.st.since_low);
      case (r.st.phase)
        PH_RST_LOW: begin
          if (reached(r.st.anchor, c.reset_low_ticks)) begin
            r.st.anchor = '0;
            r.st.phase = PH_RST_WAIT_HIGH;
          end
        end
        PH_RST_WAIT_HIGH: begin
          if (beyond(r.st.anchor, 10'(c.release_timeout))) begin
            r.st.err = first_error(r.st.err, ERR_NOT_RELEASED);
            r.st.phase = PH_RST_RECOVER;
          end else if (lvl) begin
            r.st.since_low = '0;
            r.st.phase = PH_RST_WAIT_PRES;
          end
        end
        PH_RST_WAIT_PRES: begin
          if (beyond(r.st.since_low, c.presence_window)) begin
            r.st.err = first_error(r.st.err, ERR_NO_PRESENCE);
            r.st.phase = PH_RST_RECOVER;
          end else if (!lvl) begin
            r.st.presence = 1'b1;
            r.st.phase = PH_RST_WAIT_REL;
          end
        end
        PH_RST_WAIT_REL: begin
          if (beyond(r.st.anchor, c.reset_low_ticks)) begin
            r.st.err = first_error(r.st.err, ERR_HELD_LOW);
            r.st.phase = PH_RST_RECOVER;
          end else if (lvl) begin
            r.st.phase = PH_RST_RECOVER;
          end
        end
        PH_WR_CONF_LOW, PH_RD_CONF_LOW: begin
          // a timeout goes on as if the line had been seen low
          if (beyond(r.st.anchor, 10'(c.release_timeout)) || !lvl) begin
            if (lvl) r.st.err = first_error(r.st.err, ERR_NOT_LOW);
            r.st.since_low = '0;
            r.st.phase = (r.st.phase == PH_WR_CONF_LOW) ? PH_WR_HOLD : PH_RD_HOLD;
          end
        end
        PH_WR_HOLD: begin
          hold = r.st.pend_bit ? c.write_one_low : c.write_zero_low;
          if (beyond(r.st.since_low, 10'(hold))) r.st.phase = PH_WR_WAIT_HIGH;
        end
        PH_WR_WAIT_HIGH: begin
          if (beyond(r.st.since_low, 10'(c.recover_timeout))) begin
            r.st.err = first_error(r.st.err, ERR_NOT_HIGH);
            r.st.phase = PH_WR_FINISH;
          end else if (lvl) begin
            r.st.phase = PH_WR_FINISH;
          end
        end
        PH_RD_HOLD: begin
          if (beyond(r.st.since_low, 10'(c.write_one_low))) r.st.phase = PH_RD_SAMPLE;
        end
        PH_RD_SAMPLE: begin
          if (beyond(r.st.since_low, 10'(c.read_sample_window))) begin
            r.st.sampled = 1'b0;
            r.st.phase = PH_RD_FINISH;
          end else if (lvl) begin
            r.st.sampled = 1'b1;
            r.st.phase = PH_RD_FINISH;
          end
        end
        default: ;
      endcase
      if ((r.st.phase == PH_RST_RECOVER && beyond(r.st.anchor, c.reset_low_ticks)) ||
          (r.st.phase == PH_WR_FINISH && beyond(r.st.since_low, 10'(c.write_zero_low))) ||
          (r.st.phase == PH_RD_FINISH &&
           beyond(r.st.since_low, 10'(c.read_slot_length)))) begin
        r.st.phase = PH_IDLE;
        fin = 1'b1;
      end
    end
    r.res.drive_low = (r.st.phase == PH_RST_LOW) || (r.st.phase == PH_WR_CONF_LOW) ||
                      (r.st.phase == PH_WR_HOLD) || (r.st.phase == PH_RD_CONF_LOW) ||
                      (r.st.phase == PH_RD_HOLD);
    r.res.busy = r.st.phase != PH_IDLE;
    r.res.done = fin;
    r.res.presence = r.st.presence;
    r.res.read_value = r.st.sampled;
    r.res.error_code = r.st.err;
    return r;
  endfunction

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.reset_low_ticks = RST_RESET_LOW_TICKS;
    c.release_timeout = RST_RELEASE_TIMEOUT;
    c.presence_window = RST_PRESENCE_WINDOW;
    c.write_one_low = RST_WRITE_ONE_LOW;
    c.write_zero_low = RST_WRITE_ZERO_LOW;
    c.read_sample_window = RST_READ_SAMPLE_WINDOW;
    c.read_slot_length = RST_READ_SLOT_LENGTH;
    c.recover_timeout = RST_RECOVER_TIMEOUT;
    return c;
  endfunction

  // Mostly tiny values so that operations stay short, sometimes a bit longer
  function automatic int small_value();
    return ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.reset_low_ticks = 10'(small_value());
    c.release_timeout = 8'(small_value());
    c.presence_window = 10'(small_value());
    c.write_one_low = 8'(small_value());
    c.write_zero_low = 8'(small_value());
    c.read_sample_window = 8'(small_value());
    c.read_slot_length = 8'(small_value());
    c.recover_timeout = 8'(small_value());
    return c;
  endfunction

  function automatic int capped(input int x);
    return (x > 300) ? 300 : x;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------

  // Line level seen on the next tick, given the master's state and the
  // number of ticks it has spent in that state
  function automatic logic line_level(input line_state_t s, input int tip);
    case (op_style)
      DEV_STUCK_HIGH: return 1'b1;
      DEV_STUCK_LOW:  return 1'b0;
      DEV_NOISE:      return 1'($urandom_range(1));
      default: begin
        case (s.phase)
          PH_IDLE:                                     return 1'b1;
          PH_RST_LOW, PH_WR_CONF_LOW, PH_RD_CONF_LOW:  return tip < op_lag;
          PH_WR_HOLD, PH_RD_HOLD:                      return 1'b0;
          PH_RST_WAIT_PRES:                            return tip < op_pres_at;
          PH_RST_WAIT_REL: begin
            // a slave that never lets go trips the held-low check
            if (op_style == DEV_HOLD_LOW) return 1'b0;
            return tip >= op_rel_at;
          end
          PH_RD_SAMPLE: return op_bit ? (tip >= op_lag) : (tip >= op_zero_len);
          default:      return tip >= op_lag;
        endcase
      end
    endcase
  endfunction

  task automatic push_tick(input logic [1:0] op, input logic wv, input logic lvl);
    step_t     nxt;
    tick_req_t req;
    req.op = op;
    req.wv = wv;
    req.lvl = lvl;
    pending_ticks = {pending_ticks, req};
    nxt = advance_line(plan_state, plan_cfg, op, wv, lvl);
    if (nxt.st.phase != plan_state.phase) plan_tip = 0;
    else plan_tip++;
    plan_state = nxt.st;
    planned++;
  endtask

  // Plan one whole operation; opcodes sent while busy are random and ignored
  task automatic queue_op(input logic [1:0] op, input logic wv, input int style);
    op_style = style;
    op_lag = ($urandom_range(9) == 0) ?
             $urandom_range(0, capped(plan_cfg.release_timeout + 3)) : $urandom_range(0, 2);
    op_pres_at = $urandom_range(0, capped(plan_cfg.presence_window + 2));
    op_rel_at = $urandom_range(0, capped(plan_cfg.reset_low_ticks + 2));
    op_zero_len = $urandom_range(0, capped(plan_cfg.read_sample_window + 3));
    op_bit = 1'($urandom_range(1));
    push_tick(op, wv, line_level(plan_state, plan_tip));
    while (plan_state.phase != PH_IDLE)
      push_tick(2'($urandom_range(3)), 1'($urandom_range(1)),
                line_level(plan_state, plan_tip));
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      push_tick(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      queue_op(2'($urandom_range(1, 3)), 1'($urandom_range(1)),
               (r < 65) ? DEV_NICE : (r < 73) ? DEV_STUCK_HIGH : (r < 81) ? DEV_STUCK_LOW :
               (r < 91) ? DEV_NOISE : DEV_HOLD_LOW);
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Upper data bits of an 8-bit register are don't-care: toggle them anyway
  task automatic write_narrow(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    logic [1:0] pad;
    pad = 2'($urandom_range(3));
    write_reg(idx, {pad, val});
  endtask

  task automatic apply_config(input cfg_t c);
    plan_cfg = c;
    write_reg(REG_RESET_LOW_TICKS, c.reset_low_ticks);
    write_narrow(REG_RELEASE_TIMEOUT, c.release_timeout);
    write_reg(REG_PRESENCE_WINDOW, c.presence_window);
    write_narrow(REG_WRITE_ONE_LOW, c.write_one_low);
    write_narrow(REG_WRITE_ZERO_LOW, c.write_zero_low);
    write_narrow(REG_READ_SAMPLE_WINDOW, c.read_sample_window);
    write_narrow(REG_READ_SLOT_LENGTH, c.read_slot_length);
    write_narrow(REG_RECOVER_TIMEOUT, c.recover_timeout);
    cfg_we <= 1'b0;
  endtask

  // Wait until every planned request has been taken and answered
  task automatic drain_all();
    while (accepted != planned || expected_status.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [ERR_W-1:0] got,
                             input logic [ERR_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  // --------------------------------------------------------------------------
  // Driver: present a new request at the falling edge once the previous one
  // was taken; hold valid and payload steady otherwise
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_ticks.pop_front();
        opcode <= next_req.op;
        write_value <= next_req.wv;
        bus_level <= next_req.lvl;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Request side: track register writes and predict the status of each
  // accepted tick
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RESET_LOW_TICKS:    shadow_cfg.reset_low_ticks = cfg_data;
          REG_RELEASE_TIMEOUT:    shadow_cfg.release_timeout = cfg_data[7:0];
          REG_PRESENCE_WINDOW:    shadow_cfg.presence_window = cfg_data;
          REG_WRITE_ONE_LOW:      shadow_cfg.write_one_low = cfg_data[7:0];
          REG_WRITE_ZERO_LOW:     shadow_cfg.write_zero_low = cfg_data[7:0];
          REG_READ_SAMPLE_WINDOW: shadow_cfg.read_sample_window = cfg_data[7:0];
          REG_READ_SLOT_LENGTH:   shadow_cfg.read_slot_length = cfg_data[7:0];
          REG_RECOVER_TIMEOUT:    shadow_cfg.recover_timeout = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        shadow_step = advance_line(shadow_state, shadow_cfg, opcode, write_value, bus_level);
        shadow_state = shadow_step.st;
        expected_status = {expected_status, shadow_step.res};
        accepted++;
        req_taken = 1'b1;
      end
    end
  end

  // Result side: compare every accepted status with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("status returned with no request outstanding");
      end else begin
        want = expected_status.pop_front();
        check_field("drive_low", ERR_W'(drive_low), ERR_W'(want.drive_low));
        check_field("busy_res", ERR_W'(busy_res), ERR_W'(want.busy));
        check_field("done_res", ERR_W'(done_res), ERR_W'(want.done));
        check_field("presence", ERR_W'(presence), ERR_W'(want.presence));
        check_field("read_value", ERR_W'(read_value), ERR_W'(want.read_value));
        check_field("error_code", error_code, want.error_code);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   k;
    int   mark;
    plan_state = '0;
    plan_state.phase = PH_IDLE;
    shadow_state = plan_state;
    plan_cfg = default_cfg();
    shadow_cfg = default_cfg();
    plan_tip = 0;
    planned = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // All registers zero: every limit is hit at once. Run each operation,
    // a slot whose line never falls, a read against a stuck line, and
    // plain ticks at both levels.
    c = '0;
    apply_config(c);
    queue_op(OP_RESET, 1'b0, DEV_NICE);
    queue_op(OP_WRITE, 1'b1, DEV_NICE);
    queue_op(OP_WRITE, 1'b0, DEV_STUCK_HIGH);
    queue_op(OP_READ, 1'b0, DEV_NICE);
    queue_op(OP_READ, 1'b1, DEV_STUCK_LOW);
    queue_op(OP_RESET, 1'b1, DEV_HOLD_LOW);
    push_tick(OP_TICK, 1'b1, 1'b0);
    push_tick(OP_TICK, 1'b0, 1'b1);
    drain_all();

    // Random short timings, one round per idling pattern
    for (k = 0; k < 4; k++) begin
      case (k % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 87;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 87;
        end
        default: begin
          sender_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      apply_config(random_cfg());
      mark = planned;
      while (planned - mark < 130) random_op();
      drain_all();
    end

    // Power-on timings: full length write and read slots, well-behaved slave
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    apply_config(default_cfg());
    queue_op(OP_WRITE, 1'b1, DEV_NICE);
    queue_op(OP_WRITE, 1'b0, DEV_NICE);
    queue_op(OP_READ, 1'b0, DEV_NICE);
    drain_all();

    // Long limits: with the presence window at its maximum only counter
    // saturation can end the wait for a presence pulse
    c.reset_low_ticks = 10'd6;
    c.release_timeout = 8'hFF;
    c.presence_window = 10'h3FF;
    c.write_one_low = 8'hFF;
    c.write_zero_low = 8'hFF;
    c.read_sample_window = 8'hFF;
    c.read_slot_length = 8'hFF;
    c.recover_timeout = 8'hFF;
    apply_config(c);
    queue_op(OP_RESET, 1'b1, DEV_STUCK_HIGH);
    drain_all();

    // Let any stray status show up before the verdict
    repeat (6) @(negedge clk);
    if (expected_status.size() != 0) report_mismatch("statuses still outstanding at end");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
sv/owt_pkg.sv
sv/owt_cfg.sv
sv/owt_fsm.sv
sv/one_wire_bit_timing_master.sv
sv/owt_chk.sv
verif/testbench.sv
